[rtl/uhfl_pkg.sv]
// ============================================================================
// uhfl_pkg - shared definitions of the host UART frame link
// Mode codes, framing constants and the job record handed from the
// front end to the result sequencer.
// ============================================================================
package uhfl_pkg;

  localparam int RX_DEPTH_DEF = 64;

  localparam logic [7:0] SOF_BYTE       = 8'hFE;
  localparam logic [7:0] RESP_FLAG      = 8'h80;
  localparam logic [6:0] CMD_MASK       = 7'h7F;
  localparam logic [7:0] TIMEOUT_RESET  = 8'd10;
  localparam logic [8:0] FRAME_OVERHEAD = 9'd5;

  localparam logic [2:0] MODE_RX      = 3'd0;
  localparam logic [2:0] MODE_TICK    = 3'd1;
  localparam logic [2:0] MODE_RESP    = 3'd2;
  localparam logic [2:0] MODE_PAYLOAD = 3'd3;
  localparam logic [2:0] MODE_READ    = 3'd4;

  // Header beats of a response frame.
  localparam logic [1:0] BEAT_SOF    = 2'd0;
  localparam logic [1:0] BEAT_COUNT  = 2'd1;
  localparam logic [1:0] BEAT_CMD    = 2'd2;
  localparam logic [1:0] BEAT_SERIAL = 2'd3;

  typedef enum logic [1:0] {
    JOB_PLAIN,
    JOB_HEADER,
    JOB_DATA,
    JOB_DATA_END
  } job_kind_e;

  typedef struct packed {
    logic       frame_ready;
    logic [6:0] frame_command;
    logic [7:0] read_data;
  } status_t;

  typedef struct packed {
    job_kind_e  kind;
    logic [7:0] tx_data;
    logic [7:0] serial;
    status_t    status;
  } job_t;

endpackage

[rtl/uhfl_front.sv]
// ============================================================================
// uhfl_front - accepting and classifying front end
// Holds the receive store and link state, updates them once per accepted
// item and hands a job record on through a single output stage.
// ============================================================================
module uhfl_front import uhfl_pkg::*; #(
  parameter int RX_DEPTH = RX_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [7:0] cfg_data_i,
  input  logic       push,
  output logic       full,
  input  logic [2:0] mode_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] payload_count_i,
  input  logic [5:0] read_index_i,
  output logic       job_valid_o,
  output job_t       job_o,
  input  logic       job_ready_i
);

  localparam int IDX_W = $clog2(RX_DEPTH);
  localparam int RW    = (IDX_W > 6) ? IDX_W : 6;

  logic [7:0]          mem_q [RX_DEPTH];
  logic [RX_DEPTH-1:0] filled_q;
  logic [7:0]          head0_q, head0_d, head1_q, head1_d, head2_q, head2_d;
  logic [IDX_W-1:0]    pos_q, pos_d;
  logic [7:0]          tl_q, tl_d, ticks_q, serial_q, serial_d, pl_q, pl_d;
  logic                fw_q, fw_d;

  logic                sb_valid_q;
  job_t                sb_q, job_d;
  logic [7:0]          rd_mem_q;
  logic                rd_ok_q, rd_ok_d;

  logic                accept, advance;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [7:0]          wr_data;
  logic [IDX_W:0]      nxt;
  logic [7:0]          ser;
  logic [RW-1:0]       ridx_ext;
  logic                rd_in_range;
  logic [IDX_W-1:0]    rd_addr;

  assign advance = ~sb_valid_q | job_ready_i;
  assign full    = ~advance;
  assign accept  = push & ~full;

  assign ridx_ext    = RW'(read_index_i);
  assign rd_in_range = {1'b0, ridx_ext} < (RW + 1)'(RX_DEPTH);
  assign rd_addr     = ridx_ext[IDX_W-1:0];

  always_comb begin
    head0_d  = head0_q;
    head1_d  = head1_q;
    head2_d  = head2_q;
    pos_d    = pos_q;
    tl_d     = tl_q;
    fw_d     = fw_q;
    serial_d = serial_q;
    pl_d     = pl_q;
    wr_en    = 1'b0;
    wr_addr  = pos_q;
    wr_data  = data_byte_i;
    nxt      = '0;
    ser      = serial_q;
    rd_ok_d  = 1'b0;
    job_d    = '0;
    job_d.kind = JOB_PLAIN;

    if (accept) begin
      case (mode_i)
        MODE_RX: begin
          wr_en = 1'b1;
          if (pos_q == IDX_W'(0)) head0_d = data_byte_i;
          if (pos_q == IDX_W'(1)) head1_d = data_byte_i;
          if (pos_q == IDX_W'(2)) head2_d = data_byte_i;
          nxt = {1'b0, pos_q} + (IDX_W + 1)'(1);
          if (nxt == (IDX_W + 1)'(RX_DEPTH)) nxt = '0;
          if (head0_d != SOF_BYTE) nxt = '0;
          pos_d = nxt[IDX_W-1:0];
          if (9'(nxt) >= ({1'b0, head1_d} + FRAME_OVERHEAD)) begin
            tl_d = 8'd0;
            fw_d = 1'b1;
          end else begin
            tl_d = ticks_q;
          end
        end
        MODE_TICK: begin
          if (tl_q != 8'd0) begin
            tl_d = tl_q - 8'd1;
            if (tl_q == 8'd1) pos_d = '0;
          end
        end
        MODE_RESP: begin
          fw_d  = 1'b0;
          pos_d = '0;
          if (head0_q != SOF_BYTE) begin
            head2_d = 8'd0;
            wr_en   = 1'b1;
            wr_addr = IDX_W'(2);
            wr_data = 8'd0;
          end
          pl_d = payload_count_i;
          if (payload_count_i != 8'd0) begin
            ser           = (serial_q == 8'd0) ? 8'd1 : serial_q;
            serial_d      = ser + 8'd1;
            job_d.kind    = JOB_HEADER;
            job_d.tx_data = payload_count_i;
            job_d.serial  = ser;
          end
        end
        MODE_PAYLOAD: begin
          if (pl_q != 8'd0) begin
            pl_d          = pl_q - 8'd1;
            job_d.kind    = (pl_q == 8'd1) ? JOB_DATA_END : JOB_DATA;
            job_d.tx_data = data_byte_i;
          end
        end
        MODE_READ: begin
          rd_ok_d = rd_in_range && filled_q[rd_addr];
        end
        default: begin
        end
      endcase
    end

    job_d.status.frame_ready   = fw_d;
    job_d.status.frame_command = (head0_d == SOF_BYTE) ? (head2_d[6:0] & CMD_MASK) : 7'd0;
  end

  // Receive store: written at one address, read at one, read data registered.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (accept) rd_mem_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q   <= '0;
      head0_q    <= 8'd0;
      head1_q    <= 8'd0;
      head2_q    <= 8'd0;
      pos_q      <= '0;
      tl_q       <= 8'd0;
      fw_q       <= 1'b0;
      serial_q   <= 8'd0;
      pl_q       <= 8'd0;
      ticks_q    <= TIMEOUT_RESET;
      sb_valid_q <= 1'b0;
      rd_ok_q    <= 1'b0;
    end else begin
      if (wr_en) filled_q[wr_addr] <= 1'b1;
      head0_q  <= head0_d;
      head1_q  <= head1_d;
      head2_q  <= head2_d;
      pos_q    <= pos_d;
      tl_q     <= tl_d;
      fw_q     <= fw_d;
      serial_q <= serial_d;
      pl_q     <= pl_d;
      if (cfg_valid_i) ticks_q <= cfg_data_i;
      if (advance) sb_valid_q <= accept;
      if (accept) rd_ok_q <= rd_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) sb_q <= job_d;
  end

  always_comb begin
    job_o                  = sb_q;
    job_o.status.read_data = rd_ok_q ? rd_mem_q : 8'd0;
  end

  assign job_valid_o = sb_valid_q;

endmodule

[rtl/uhfl_queue.sv]
// ============================================================================
// uhfl_queue - two-entry job queue
// Decouples the front end from the result sequencer.
// ============================================================================
module uhfl_queue import uhfl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  job_t wr_job_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output job_t rd_job_o
);

  job_t       slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;
  logic       do_wr, do_rd;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign do_wr      = wr_valid_i & wr_ready_o;
  assign do_rd      = rd_ready_i & rd_valid_o;
  assign rd_job_o   = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) slot_q[wptr_q] <= wr_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_wr) wptr_q <= ~wptr_q;
      if (do_rd) rptr_q <= ~rptr_q;
      case ({do_wr, do_rd})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[rtl/uhfl_back.sv]
// ============================================================================
// uhfl_back - result sequencer
// Expands each job into its one to four result transfers, one a cycle while pop is high.
// ============================================================================
module uhfl_back import uhfl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  output logic       job_ready_o,
  input  job_t       job_i,
  output logic       empty,
  input  logic       pop,
  output logic       tx_valid_o,
  output logic [7:0] tx_byte_o,
  output logic       last_o,
  output logic       frame_ready_o,
  output logic [6:0] frame_command_o,
  output logic [7:0] read_data_o
);

  logic       cur_valid_q;
  job_t       cur_q;
  logic [1:0] beat_q;
  logic [1:0] final_beat;
  logic       is_last, take, load;

  always_comb begin
    case (cur_q.kind)
      JOB_HEADER:   final_beat = BEAT_SERIAL;
      JOB_DATA_END: final_beat = 2'd1;
      default:      final_beat = 2'd0;
    endcase
  end

  assign is_last     = (beat_q == final_beat);
  assign take        = ~cur_valid_q | (pop & is_last);
  assign job_ready_o = take;
  assign load        = take & job_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      beat_q      <= 2'd0;
    end else if (take) begin
      cur_valid_q <= job_valid_i;
      beat_q      <= 2'd0;
    end else if (pop) begin
      beat_q <= beat_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) cur_q <= job_i;
  end

  always_comb begin
    tx_byte_o = 8'd0;
    case (cur_q.kind)
      JOB_HEADER: begin
        case (beat_q)
          BEAT_SOF:    tx_byte_o = SOF_BYTE;
          BEAT_COUNT:  tx_byte_o = cur_q.tx_data;
          BEAT_CMD:    tx_byte_o = RESP_FLAG | {1'b0, cur_q.status.frame_command};
          BEAT_SERIAL: tx_byte_o = cur_q.serial;
          default:     tx_byte_o = 8'd0;
        endcase
      end
      JOB_DATA:     tx_byte_o = cur_q.tx_data;
      JOB_DATA_END: tx_byte_o = (beat_q == 2'd0) ? cur_q.tx_data : SOF_BYTE;
      default:      tx_byte_o = 8'd0;
    endcase
  end

  assign empty           = ~cur_valid_q;
  assign tx_valid_o      = (cur_q.kind != JOB_PLAIN);
  assign last_o          = is_last;
  assign frame_ready_o   = cur_q.status.frame_ready;
  assign frame_command_o = cur_q.status.frame_command;
  assign read_data_o     = cur_q.status.read_data;

endmodule

[rtl/uart_host_frame_link_core.sv]
// ============================================================================
// uart_host_frame_link_core - host UART receive and response framer
// Stores received frames, runs the inter-byte timeout and builds response
// frames (header, payload, trailer) as a stream of result transfers.
// ============================================================================
//
//  channel   handshake                 direction  payload
//  --------  ------------------------  ---------  ----------------------------
//  input     push / full               in         mode, data_byte,
//                                                 payload_count, read_index
//  result    empty / pop               out        tx_valid, tx_byte, last,
//                                                 frame_ready, frame_command,
//                                                 read_data
//  config    cfg_valid_i / cfg_ready_o in         cfg_data_i (rx_timeout_ticks)
//
// One item is accepted per cycle while full is low. A received byte, tick,
// read or payload byte gives one result (two for the final payload byte); a
// response start with a nonzero count gives four, delivered by the result
// sequencer one per cycle while pop is high. The first result of an item
// reaches the result ports through the front end's output stage, which takes
// the state update and the registered store read on acceptance, then through
// the job queue and the result sequencer's register. Reset clears all state
// at once; store entries carry a written flag so an unwritten entry reads as
// zero, and no clearing pass is needed. When pop is held low the two-entry job
// queue and the front end's output stage fill, and full then rises.
//
module uart_host_frame_link_core import uhfl_pkg::*; #(
  parameter int RX_DEPTH = RX_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  input  logic       push,
  output logic       full,
  input  logic [2:0] mode_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] payload_count_i,
  input  logic [5:0] read_index_i,
  output logic       empty,
  input  logic       pop,
  output logic       tx_valid_o,
  output logic [7:0] tx_byte_o,
  output logic       last_o,
  output logic       frame_ready_o,
  output logic [6:0] frame_command_o,
  output logic [7:0] read_data_o
);

  // Configuration writes are taken in any cycle.
  assign cfg_ready_o = 1'b1;

  logic fe_valid, fe_ready;
  job_t fe_job;
  logic q_valid, q_ready;
  job_t q_job;

  // Front end: accepts items, updates the store and link state, and issues
  // a job that describes the results the item causes.
  uhfl_front #(
    .RX_DEPTH (RX_DEPTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .push            (push),
    .full            (full),
    .mode_i          (mode_i),
    .data_byte_i     (data_byte_i),
    .payload_count_i (payload_count_i),
    .read_index_i    (read_index_i),
    .job_valid_o     (fe_valid),
    .job_o           (fe_job),
    .job_ready_i     (fe_ready)
  );

  // The queue lets the front end keep taking items while a multi-beat
  // header is still being delivered.
  uhfl_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fe_valid),
    .wr_ready_o (fe_ready),
    .wr_job_i   (fe_job),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_job_o   (q_job)
  );

  // Back end: turns each job into its result transfers.
  uhfl_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (q_valid),
    .job_ready_o     (q_ready),
    .job_i           (q_job),
    .empty           (empty),
    .pop             (pop),
    .tx_valid_o      (tx_valid_o),
    .tx_byte_o       (tx_byte_o),
    .last_o          (last_o),
    .frame_ready_o   (frame_ready_o),
    .frame_command_o (frame_command_o),
    .read_data_o     (read_data_o)
  );

endmodule

[tb/sv/uart_host_frame_link_core_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// uart_host_frame_link_core_checker - result checker of the host frame link
// Watches the input, configuration and result channels, keeps its own model
// of the receive store and the response framer, and compares every result
// transfer with the oldest predicted result.
// ============================================================================
module uart_host_frame_link_core_checker import uhfl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [7:0] cfg_data_i,
  input  logic       push_i,
  input  logic       full_i,
  input  logic [2:0] mode_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] payload_count_i,
  input  logic [5:0] read_index_i,
  input  logic       empty_i,
  input  logic       pop_i,
  input  logic       tx_valid_i,
  input  logic [7:0] tx_byte_i,
  input  logic       last_i,
  input  logic       frame_ready_i,
  input  logic [6:0] frame_command_i,
  input  logic [7:0] read_data_i,
  input  logic       end_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
    logic       frame_ready;
    logic [6:0] frame_command;
    logic [7:0] read_data;
  } link_result_t;

  logic [7:0]                      rx_mem [RX_DEPTH_DEF];
  logic [$clog2(RX_DEPTH_DEF)-1:0] rx_wr_pos;
  logic [7:0]                      tick_left;
  logic                            frame_held;
  logic [7:0]                      serial_ctr;
  logic [7:0]                      payload_owed;
  logic [7:0]                      timeout_reload;
  link_result_t                    due_results [$];

  // Command of the stored frame; zero unless the start byte is good.
  function automatic logic [6:0] stored_command();
    if (rx_mem[0] != SOF_BYTE) return '0;
    return rx_mem[2][6:0] & CMD_MASK;
  endfunction

  function automatic link_result_t make_result(input logic       valid,
                                               input logic [7:0] tx_b,
                                               input logic [7:0] rd);
    link_result_t r;
    r.tx_valid      = valid;
    r.tx_byte       = tx_b;
    r.last          = 1'b0;
    r.frame_ready   = frame_held;
    r.frame_command = stored_command();
    r.read_data     = rd;
    return r;
  endfunction

  task automatic predict_link_results(input logic [2:0] m, input logic [7:0] d,
                                      input logic [7:0] c, input logic [5:0] ix);
    link_result_t batch [4];
    int           n;
    n = 0;
    case (m)
      MODE_RX: begin
        tick_left = timeout_reload;
        rx_mem[rx_wr_pos] = d;
        rx_wr_pos = rx_wr_pos + 1'b1;
        if (rx_mem[0] != SOF_BYTE) rx_wr_pos = '0;
        if ({3'b000, rx_wr_pos} >= {1'b0, rx_mem[1]} + FRAME_OVERHEAD) begin
          tick_left  = '0;
          frame_held = 1'b1;
        end
        batch[n] = make_result(1'b0, 8'h00, 8'h00);
        n++;
      end
      MODE_TICK: begin
        if (tick_left != 0) begin
          tick_left = tick_left - 1'b1;
          if (tick_left == 0) rx_wr_pos = '0;
        end
        batch[n] = make_result(1'b0, 8'h00, 8'h00);
        n++;
      end
      MODE_RESP: begin
        frame_held = 1'b0;
        rx_wr_pos  = '0;
        if (rx_mem[0] != SOF_BYTE) rx_mem[2] = '0;
        payload_owed = c;
        if (c == 0) begin
          batch[n] = make_result(1'b0, 8'h00, 8'h00);
          n++;
        end else begin
          if (serial_ctr == 0) serial_ctr = 8'd1;
          batch[0] = make_result(1'b1, SOF_BYTE, 8'h00);
          batch[1] = make_result(1'b1, c, 8'h00);
          batch[2] = make_result(1'b1, {1'b0, stored_command()} | RESP_FLAG, 8'h00);
          batch[3] = make_result(1'b1, serial_ctr, 8'h00);
          n = 4;
          serial_ctr = serial_ctr + 1'b1;
        end
      end
      MODE_PAYLOAD: begin
        if (payload_owed == 0) begin
          batch[n] = make_result(1'b0, 8'h00, 8'h00);
          n++;
        end else begin
          payload_owed = payload_owed - 1'b1;
          batch[n] = make_result(1'b1, d, 8'h00);
          n++;
          if (payload_owed == 0) begin
            batch[n] = make_result(1'b1, SOF_BYTE, 8'h00);
            n++;
          end
        end
      end
      MODE_READ: begin
        batch[n] = make_result(1'b0, 8'h00, rx_mem[ix]);
        n++;
      end
      default: begin
        batch[n] = make_result(1'b0, 8'h00, 8'h00);
        n++;
      end
    endcase
    batch[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) due_results.push_back(batch[k]);
  endtask

  task automatic check_result();
    link_result_t got;
    link_result_t want;
    got.tx_valid      = tx_valid_i;
    got.tx_byte       = tx_byte_i;
    got.last          = last_i;
    got.frame_ready   = frame_ready_i;
    got.frame_command = frame_command_i;
    got.read_data     = read_data_i;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected result transfer: tx_valid=%0b tx_byte=%02h last=%0b",
               $time, got.tx_valid, got.tx_byte, got.last);
      $display("%0t:   ready=%0b cmd=%02h rd=%02h",
               $time, got.frame_ready, got.frame_command, got.read_data);
      fail_count_o++;
      return;
    end
    want = due_results.pop_front();
    if (got !== want) begin
      $display("%0t: mismatch, expected tx_valid=%0b tx_byte=%02h last=%0b",
               $time, want.tx_valid, want.tx_byte, want.last);
      $display("%0t:   expected ready=%0b cmd=%02h rd=%02h",
               $time, want.frame_ready, want.frame_command, want.read_data);
      $display("%0t: mismatch, actual   tx_valid=%0b tx_byte=%02h last=%0b",
               $time, got.tx_valid, got.tx_byte, got.last);
      $display("%0t:   actual   ready=%0b cmd=%02h rd=%02h",
               $time, got.frame_ready, got.frame_command, got.read_data);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RX_DEPTH_DEF; k++) rx_mem[k] = '0;
      rx_wr_pos      = '0;
      tick_left      = '0;
      frame_held     = 1'b0;
      serial_ctr     = '0;
      payload_owed   = '0;
      timeout_reload = TIMEOUT_RESET;
      due_results.delete();
    end else begin
      if (pop_i && !empty_i) check_result();
      if (cfg_valid_i && cfg_ready_i) timeout_reload = cfg_data_i;
      if (push_i && !full_i) begin
        predict_link_results(mode_i, data_byte_i, payload_count_i, read_index_i);
      end
      if (end_i && due_results.size() != 0) begin
        $display("%0t: %0d predicted results never arrived, expected 0 left, actual %0d",
                 $time, due_results.size(), due_results.size());
        fail_count_o += due_results.size();
        due_results.delete();
      end
    end
    pending_o = due_results.size();
  end

endmodule

[tb/sv/uart_host_frame_link_core_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// uart_host_frame_link_core_tb - testbench of the host UART frame link
// Drives received frames, ticks, response starts, payload bytes and store
// reads through the push/full side, pops results at random, and leaves the
// prediction and comparison to the checker instantiated beside the block.
// ============================================================================
module uart_host_frame_link_core_tb;
  import uhfl_pkg::*;

  // Clock and reset. Reset is held at the start and then released for good.
  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;

  // Configuration channel.
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data  = 8'h00;

  // Input channel.
  logic       push          = 1'b0;
  logic       full;
  logic [2:0] mode          = MODE_RX;
  logic [7:0] data_byte     = 8'h00;
  logic [7:0] payload_count = 8'h00;
  logic [5:0] read_index    = 6'd0;

  // Result channel.
  logic       empty;
  logic       pop = 1'b0;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       last_item;
  logic       frame_ready;
  logic [6:0] frame_command;
  logic [7:0] read_data;

  // Control between the stimulus process and the receiver process.
  logic       calm        = 1'b0;  // no idling on either side while set
  logic       hold_toggle = 1'b0;  // each change starts one long receiver stall
  logic       end_check   = 1'b0;
  int         fail_count;
  int         pending;
  int         items_sent  = 0;

  always #2 clk_i = ~clk_i;

  uart_host_frame_link_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .push            (push),
    .full            (full),
    .mode_i          (mode),
    .data_byte_i     (data_byte),
    .payload_count_i (payload_count),
    .read_index_i    (read_index),
    .empty           (empty),
    .pop             (pop),
    .tx_valid_o      (tx_valid),
    .tx_byte_o       (tx_byte),
    .last_o          (last_item),
    .frame_ready_o   (frame_ready),
    .frame_command_o (frame_command),
    .read_data_o     (read_data)
  );

  uart_host_frame_link_core_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .push_i          (push),
    .full_i          (full),
    .mode_i          (mode),
    .data_byte_i     (data_byte),
    .payload_count_i (payload_count),
    .read_index_i    (read_index),
    .empty_i         (empty),
    .pop_i           (pop),
    .tx_valid_i      (tx_valid),
    .tx_byte_i       (tx_byte),
    .last_i          (last_item),
    .frame_ready_i   (frame_ready),
    .frame_command_i (frame_command),
    .read_data_i     (read_data),
    .end_i           (end_check),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Offers one item and returns at the edge at which its transfer happens.
  // Before the offer the sender may idle at random; push is given a single
  // assignment per edge, so a run of back-to-back items keeps it high.
  task automatic send_item(input logic [2:0] m, input logic [7:0] d,
                           input logic [7:0] c, input logic [5:0] ix);
    while (!calm && $urandom_range(99) < 37) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push          <= 1'b1;
    mode          <= m;
    data_byte     <= d;
    payload_count <= c;
    read_index    <= ix;
    do @(posedge clk_i); while (full);
    items_sent++;
  endtask

  // Sends the first 'cut' bytes of a received frame of payload length 'len'.
  // A bad start puts a byte other than the start byte in front. Ticks are
  // slipped in between bytes now and then, so short timeouts drop frames.
  task automatic send_frame(input int len, input bit good_start, input int cut);
    logic [7:0] b;
    int         total;
    total = len + 5;
    if (cut < total) total = cut;
    for (int k = 0; k < total; k++) begin
      case (k)
        0:       b = good_start ? SOF_BYTE : 8'($urandom_range(253));
        1:       b = 8'(len);
        default: b = 8'($urandom);
      endcase
      send_item(MODE_RX, b, 8'($urandom), 6'($urandom));
      if ($urandom_range(99) < 12) begin
        send_item(MODE_TICK, 8'($urandom), 8'($urandom), 6'($urandom));
      end
    end
  endtask

  // Response start with count 'cnt', followed by 'nbytes' payload bytes.
  task automatic send_response(input logic [7:0] cnt, input int nbytes);
    send_item(MODE_RESP, 8'($urandom), cnt, 6'($urandom));
    for (int k = 0; k < nbytes; k++) begin
      send_item(MODE_PAYLOAD, 8'($urandom), 8'($urandom), 6'($urandom));
    end
  endtask

  // Stops offering items and waits until every predicted result has been
  // popped, then lets the block's pipeline run empty.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One random piece of traffic. The largest share of it is a whole exchange:
  // a frame that completes, followed by a response and its payload. The rest
  // is broken or overlong frames, tick bursts, store reads and plain noise.
  task automatic random_action();
    int pick;
    int len;
    int cnt;
    int nbytes;
    pick = $urandom_range(99);
    if (pick < 45) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(58, 7) : $urandom_range(6);
      send_frame(len, 1'b1, len + 5);
      if ($urandom_range(3) == 0) begin
        send_item(MODE_READ, 8'($urandom), 8'($urandom), 6'($urandom));
      end
      pick = $urandom_range(99);
      if (pick < 8) cnt = 0;
      else if (pick < 93) cnt = $urandom_range(6, 1);
      else cnt = $urandom_range(40, 7);
      nbytes = cnt;
      pick = $urandom_range(99);
      if (pick < 8 && cnt > 0) nbytes = cnt - 1;
      else if (pick < 13) nbytes = cnt + 2;
      send_response(8'(cnt), nbytes);
    end else if (pick < 55) begin
      case ($urandom_range(2))
        0:       send_frame($urandom_range(255, 59), 1'b1, $urandom_range(12, 3));
        1:       send_frame($urandom_range(6), 1'b0, $urandom_range(6, 1));
        default: begin
          len = $urandom_range(10);
          send_frame(len, 1'b1, $urandom_range(len + 4, 1));
        end
      endcase
    end else if (pick < 70) begin
      repeat ($urandom_range(12, 1)) begin
        send_item(MODE_TICK, 8'($urandom), 8'($urandom), 6'($urandom));
      end
    end else if (pick < 85) begin
      repeat ($urandom_range(3, 1)) begin
        send_item(MODE_READ, 8'($urandom), 8'($urandom), 6'($urandom));
      end
    end else begin
      repeat ($urandom_range(4, 1)) begin
        send_item(3'($urandom_range(7)), 8'($urandom), 8'($urandom), 6'($urandom));
      end
    end
  endtask

  task automatic random_traffic(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) random_action();
  endtask

  // Receiver. Pops at random unless a long stall has been requested, which
  // this process counts out itself, or idling is switched off.
  initial begin : receiver
    logic hold_seen;
    int   hold_left;
    hold_seen = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (calm) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= 37);
      end
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset timeout. Reads of the cleared store at both ends, a payload byte
    // with no response open, a zero count response on a bad start byte, a
    // shortest frame whose command has its top bit set, a one byte response,
    // the unused modes and a response of the largest count.
    send_item(MODE_READ, 8'hFF, 8'hFF, 6'd0);
    send_item(MODE_READ, 8'h00, 8'h00, 6'd63);
    send_item(MODE_PAYLOAD, 8'hFF, 8'h00, 6'd0);
    send_item(MODE_RESP, 8'h00, 8'h00, 6'd0);
    send_item(MODE_RX, SOF_BYTE, 8'h00, 6'd0);
    send_item(MODE_RX, 8'h00, 8'h00, 6'd0);
    send_item(MODE_RX, 8'h85, 8'h00, 6'd0);
    send_item(MODE_RX, 8'h01, 8'h00, 6'd0);
    send_item(MODE_RX, 8'hFF, 8'h00, 6'd0);
    send_item(MODE_READ, 8'h00, 8'h00, 6'd2);
    send_response(8'd1, 1);
    send_item(3'd5, 8'hFF, 8'hFF, 6'd63);
    send_item(3'd6, 8'h00, 8'h00, 6'd0);
    send_item(3'd7, 8'hFF, 8'hFF, 6'd63);
    send_response(8'd255, 1);

    // Shortest timeout: a bad start byte keeps the index at zero, and an
    // overlong frame is dropped by a single tick before a good frame follows.
    settle();
    write_timeout(8'd1);
    send_item(MODE_RX, 8'h00, 8'h00, 6'd0);
    send_item(MODE_READ, 8'h00, 8'h00, 6'd0);
    send_frame(255, 1'b1, 3);
    send_item(MODE_TICK, 8'h00, 8'h00, 6'd0);
    send_item(MODE_RX, SOF_BYTE, 8'h00, 6'd0);
    send_item(MODE_RX, 8'h00, 8'h00, 6'd0);
    send_item(MODE_RX, 8'h05, 8'h00, 6'd0);
    send_item(MODE_RX, 8'h06, 8'h00, 6'd0);
    send_item(MODE_RX, 8'h07, 8'h00, 6'd0);
    send_response(8'd2, 2);
    random_traffic(15);

    // Longest timeout, with a long receiver stall while items keep coming,
    // so the block fills up and holds its input off.
    settle();
    write_timeout(8'd255);
    hold_toggle <= ~hold_toggle;
    random_traffic(20);

    // Zero timeout: ticks in the middle of a frame must not drop it.
    settle();
    write_timeout(8'd0);
    send_item(MODE_RESP, 8'h00, 8'h00, 6'd0);
    send_item(MODE_RX, SOF_BYTE, 8'h00, 6'd0);
    send_item(MODE_RX, 8'h03, 8'h00, 6'd0);
    repeat (3) send_item(MODE_TICK, 8'h00, 8'h00, 6'd0);
    repeat (6) send_item(MODE_RX, 8'($urandom), 8'($urandom), 6'($urandom));
    send_item(MODE_READ, 8'h00, 8'h00, 6'd3);
    send_response(8'd3, 3);
    random_traffic(10);

    // A random short timeout. The sender pauses until everything is out,
    // then a run of response starts takes the serial number through its wrap.
    settle();
    write_timeout(8'($urandom_range(20, 2)));
    random_traffic(10);
    settle();
    repeat (256) send_item(MODE_RESP, 8'($urandom), 8'($urandom_range(255, 1)),
                           6'($urandom));
    random_traffic(10);

    // Back to the reset timeout, first with no idling on either side.
    settle();
    write_timeout(TIMEOUT_RESET);
    calm <= 1'b1;
    random_traffic(15);
    calm <= 1'b0;
    random_traffic(5);

    settle();
    repeat (8) @(posedge clk_i);
    end_check <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: the slowest correct run ends far earlier than this.
  initial begin : watchdog
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
